/* sv/esrdp_pkg.sv */
package esrdp_pkg;

   localparam int unsigned CENTER_W = 12;
   localparam int unsigned GAIN_W   = 4;
   localparam int unsigned LIMIT_W  = 7;
   localparam int unsigned STEP_W   = 7;
   localparam int unsigned SPEED_W  = 8;
   localparam int unsigned INDEX_W  = 7;
   localparam int unsigned PULSE_W  = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [CENTER_W-1:0] CENTER_RST = 12'd1500;
   localparam logic [GAIN_W-1:0]   GAIN_RST   = 4'd5;
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 7'd100;
   localparam logic [STEP_W-1:0]   STEP_RST   = 7'd10;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_RAMP = 2'd1,
      PHASE_RUN  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER = 2'd0,
      CSR_GAIN   = 2'd1,
      CSR_LIMIT  = 2'd2,
      CSR_STEP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center;
      logic [GAIN_W-1:0]   gain;
      logic [LIMIT_W-1:0]  limit;
      logic [STEP_W-1:0]   step;
   } cfg_type;

   typedef struct packed {
      logic                      prev_a;
      logic signed [SPEED_W-1:0] setpoint;
      logic                      coarse;
      phase_type                 phase;
      logic [INDEX_W-1:0]        ramp_index;
   } state_type;

   typedef struct packed {
      logic enc_a;
      logic enc_b;
      logic mode_press;
      logic deadman_held;
      logic ramp_tick;
   } sample_type;

   typedef struct packed {
      logic                      drive_enable;
      logic [PULSE_W-1:0]        pulse_fwd;
      logic [PULSE_W-1:0]        pulse_rev;
      phase_type                 phase;
      logic signed [SPEED_W-1:0] shown_speed;
      logic signed [SPEED_W-1:0] target_speed;
      logic                      coarse_active;
   } result_type;

endpackage

/* sv/esrdp_step.sv */
module esrdp_step (
   input  esrdp_pkg::cfg_type    cfg,
   input  esrdp_pkg::state_type  state,
   input  esrdp_pkg::sample_type sample,
   output esrdp_pkg::state_type  state_nx,
   output esrdp_pkg::result_type result
);
   import esrdp_pkg::*;

   function automatic logic [PULSE_W-1:0] sat_pulse(input logic signed [13:0] v);
      logic [PULSE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 14'sd4095) begin
         r = '1;
      end else begin
         r = v[PULSE_W-1:0];
      end
      return r;
   endfunction

   logic                      idle;
   logic                      coarse_nx;
   logic                      a_rise;
   logic signed [9:0]         step_s;
   logic signed [9:0]         lim_s;
   logic signed [9:0]         sp_sum;
   logic signed [9:0]         sp_clamp;
   logic signed [SPEED_W-1:0] sp_nx;
   logic [SPEED_W-1:0]        sp_neg;
   logic [INDEX_W-1:0]        mag;
   logic                      drive;
   phase_type                 phase_nx;
   logic [INDEX_W-1:0]        idx_nx;
   logic signed [SPEED_W-1:0] speed;
   logic signed [12:0]        gain_s;
   logic signed [12:0]        speed_s;
   logic signed [12:0]        delta;
   logic signed [13:0]        fwd_sum;
   logic signed [13:0]        rev_sum;

   // setpoint update, only while idle
   always_comb begin
      idle      = (state.phase == PHASE_IDLE);
      coarse_nx = (idle && sample.mode_press) ? ~state.coarse : state.coarse;
      a_rise    = !state.prev_a && sample.enc_a;
      step_s    = coarse_nx ? signed'({3'b000, cfg.step}) : 10'sd1;
      lim_s     = signed'({3'b000, cfg.limit});
      sp_sum    = 10'(state.setpoint);
      if (a_rise) begin
         sp_sum = sample.enc_b ? sp_sum + step_s : sp_sum - step_s;
      end
      if (sp_sum > lim_s) begin
         sp_clamp = lim_s;
      end else if (sp_sum < -lim_s) begin
         sp_clamp = -lim_s;
      end else begin
         sp_clamp = sp_sum;
      end
      sp_nx  = idle ? sp_clamp[SPEED_W-1:0] : state.setpoint;
      sp_neg = 8'(-sp_nx);
      mag    = sp_nx[SPEED_W-1] ? sp_neg[INDEX_W-1:0] : sp_nx[INDEX_W-1:0];
   end

   // ramp
   always_comb begin
      drive    = sample.deadman_held && (sp_nx != '0);
      phase_nx = state.phase;
      idx_nx   = state.ramp_index;
      if (drive) begin
         case (state.phase)
            PHASE_IDLE: begin
               phase_nx = PHASE_RAMP;
               idx_nx   = '0;
            end
            PHASE_RAMP: begin
               if (sample.ramp_tick) begin
                  idx_nx = state.ramp_index + 7'd1;
               end
            end
            default: ;
         endcase
         if (phase_nx == PHASE_RAMP && idx_nx >= mag) begin
            phase_nx = PHASE_RUN;
         end
         if (phase_nx == PHASE_RUN) begin
            idx_nx = mag;
         end
      end else begin
         phase_nx = PHASE_IDLE;
         idx_nx   = '0;
      end
   end

   // pulse widths
   always_comb begin
      if (!drive) begin
         speed = '0;
      end else if (sp_nx[SPEED_W-1]) begin
         speed = -signed'({1'b0, idx_nx});
      end else begin
         speed = signed'({1'b0, idx_nx});
      end
      gain_s  = signed'({9'd0, cfg.gain});
      speed_s = 13'(speed);
      delta   = gain_s * speed_s;
      fwd_sum = signed'({2'b00, cfg.center}) + 14'(delta);
      rev_sum = signed'({2'b00, cfg.center}) - 14'(delta);
   end

   always_comb begin
      state_nx.prev_a     = sample.enc_a;
      state_nx.setpoint   = sp_nx;
      state_nx.coarse     = coarse_nx;
      state_nx.phase      = phase_nx;
      state_nx.ramp_index = idx_nx;

      result.drive_enable  = drive;
      result.pulse_fwd     = drive ? sat_pulse(fwd_sum) : '0;
      result.pulse_rev     = drive ? sat_pulse(rev_sum) : '0;
      result.phase         = phase_nx;
      result.shown_speed   = speed;
      result.target_speed  = sp_nx;
      result.coarse_active = coarse_nx;
   end

endmodule

/* sv/encoder_speed_ramp_dual_pulse_core.sv */
// channel | direction | handshake        | payload
// req     | in        | req_valid/ready  | enc_a, enc_b, mode_press, deadman_held, ramp_tick
// rsp     | out       | rsp_valid/ready  | drive_enable, pulse_fwd/rev, phase_code, speeds, coarse
// csr     | in        | csr_we           | csr_index, csr_wdata (no read-back)
//
// One word in, one word out. A word passes through the input register, then the whole
// update (setpoint, ramp, pulse multiply and saturate) into the result register.
// Sustains one word per cycle if rsp is ready; state advances only when a word moves
// into the result register. A stalled rsp holds its word and backs up req after one
// word. Synchronous active-high reset restores register defaults and idle drive state.
module encoder_speed_ramp_dual_pulse_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_enc_a,
   input  logic                                 req_enc_b,
   input  logic                                 req_mode_press,
   input  logic                                 req_deadman_held,
   input  logic                                 req_ramp_tick,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_enable,
   output logic [esrdp_pkg::PULSE_W-1:0]        rsp_pulse_fwd,
   output logic [esrdp_pkg::PULSE_W-1:0]        rsp_pulse_rev,
   output logic [1:0]                           rsp_phase_code,
   output logic signed [esrdp_pkg::SPEED_W-1:0] rsp_shown_speed,
   output logic signed [esrdp_pkg::SPEED_W-1:0] rsp_target_speed,
   output logic                                 rsp_coarse_active,
   input  logic                                 csr_we,
   input  logic [esrdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [esrdp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import esrdp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   sample_type sample_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   state_type  step_state;
   result_type step_result;
   logic       advance;

   esrdp_step u_step (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .sample   (sample_ff),
      .state_nx (step_state),
      .result   (step_result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER: cfg_in.center = csr_wdata[CENTER_W-1:0];
            CSR_GAIN:   cfg_in.gain   = csr_wdata[GAIN_W-1:0];
            CSR_LIMIT:  cfg_in.limit  = csr_wdata[LIMIT_W-1:0];
            CSR_STEP:   cfg_in.step   = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
      state_in     = advance ? step_state : state_ff;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center       <= CENTER_RST;
         cfg_ff.gain         <= GAIN_RST;
         cfg_ff.limit        <= LIMIT_RST;
         cfg_ff.step         <= STEP_RST;
         state_ff.prev_a     <= 1'b0;
         state_ff.setpoint   <= '0;
         state_ff.coarse     <= 1'b1;
         state_ff.phase      <= PHASE_IDLE;
         state_ff.ramp_index <= '0;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff.enc_a        <= req_enc_a;
         sample_ff.enc_b        <= req_enc_b;
         sample_ff.mode_press   <= req_mode_press;
         sample_ff.deadman_held <= req_deadman_held;
         sample_ff.ramp_tick    <= req_ramp_tick;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_enable  = result_ff.drive_enable;
   assign rsp_pulse_fwd     = result_ff.pulse_fwd;
   assign rsp_pulse_rev     = result_ff.pulse_rev;
   assign rsp_phase_code    = result_ff.phase;
   assign rsp_shown_speed   = result_ff.shown_speed;
   assign rsp_target_speed  = result_ff.target_speed;
   assign rsp_coarse_active = result_ff.coarse_active;

   // detached drive shows no pulses and no speed
   a_detached_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.drive_enable |->
         result_ff.pulse_fwd == '0 && result_ff.pulse_rev == '0
         && result_ff.shown_speed == '0)
      else $error("detached word carries pulse or speed");

   a_idle_index_zero : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PHASE_IDLE |-> state_ff.ramp_index == '0)
      else $error("ramp index not cleared in idle");

   a_driving_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PHASE_IDLE |-> state_ff.setpoint != '0)
      else $error("driving with zero setpoint");

   // setpoint frozen while the drive is active
   a_setpoint_frozen : assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.phase != PHASE_IDLE |=>
         state_ff.setpoint == $past(state_ff.setpoint))
      else $error("setpoint moved while driving");

endmodule
